FILE: rtl/crp_pkg.sv
`timescale 1ns / 1ps
// Card reader reply parser package: beat types, op codes, reply layout constants
// and the nibble to ASCII hex helper. No dependencies.
package crp_pkg;

  localparam int PAYLOAD_LEN = 80;
  localparam int POS_W       = 7;
  localparam int STATUS_POS  = 8;
  localparam int NUMBER_POS  = 10;
  localparam int PREFIX_LEN  = 3;
  localparam int NUMBER_LEN  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CARD_OK  = 8'h43;
  localparam logic [7:0] PREFIX_0 = 8'h52;  // 'R'
  localparam logic [7:0] PREFIX_1 = 8'h45;  // 'E'
  localparam logic [7:0] PREFIX_2 = 8'h53;  // 'S'

  typedef enum logic [1:0] {
    OP_BYTE    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_EXTRACT = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } crp_in_t;

  typedef struct packed {
    logic        card_found;
    logic [31:0] card_number;
    logic [31:0] hex_text_high;
    logic [31:0] hex_text_low;
  } crp_out_t;

  typedef struct packed {
    logic        card_ok;
    logic [31:0] number;
  } crp_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } crp_q_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] v;
    v = {4'h0, nib};
    if (nib <= 4'd9) begin
      hex_char = v + 8'h30;
    end else begin
      hex_char = v + 8'h37;  // 'A' - 10
    end
  endfunction

endpackage

FILE: rtl/crp_front.sv
`timescale 1ns / 1ps
// Front end: byte position counter and capture registers, classifies each beat
// and posts extract requests to the queue. Depends on crp_pkg.
module crp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  crp_pkg::crp_in_t  in_beat,
  output logic              req_push,
  output crp_pkg::crp_req_t req
);
  import crp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       prefix_r [PREFIX_LEN];
  logic [7:0]       prefix_nxt [PREFIX_LEN];
  logic [7:0]       status_r, status_nxt;
  logic [7:0]       number_r [NUMBER_LEN];
  logic [7:0]       number_nxt [NUMBER_LEN];
  logic             is_res;

  always_comb begin
    pos_nxt    = pos_r;
    prefix_nxt = prefix_r;
    status_nxt = status_r;
    number_nxt = number_r;
    req_push   = 1'b0;
    if (take) begin
      unique case (in_beat.op)
        OP_BYTE: begin
          if (pos_r < POS_W'(PAYLOAD_LEN)) begin
            for (int i = 0; i < PREFIX_LEN; i++) begin
              if (pos_r == POS_W'(i)) prefix_nxt[i] = in_beat.rx_byte;
            end
            if (pos_r == POS_W'(STATUS_POS)) status_nxt = in_beat.rx_byte;
            for (int i = 0; i < NUMBER_LEN; i++) begin
              if (pos_r == POS_W'(NUMBER_POS + i)) number_nxt[i] = in_beat.rx_byte;
            end
            pos_nxt = pos_r + 1'b1;
          end else begin
            pos_nxt = '0;
          end
        end
        OP_CLEAR: begin
          pos_nxt    = '0;
          prefix_nxt = '{default: 8'h00};
          status_nxt = 8'h00;
          number_nxt = '{default: 8'h00};
        end
        OP_EXTRACT: begin
          req_push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign is_res = (prefix_r[0] == PREFIX_0) && (prefix_r[1] == PREFIX_1) &&
                  (prefix_r[2] == PREFIX_2);
  assign req.card_ok = !is_res && (status_r == CARD_OK);
  assign req.number  = {number_r[0], number_r[1], number_r[2], number_r[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      prefix_r <= '{default: 8'h00};
      status_r <= 8'h00;
      number_r <= '{default: 8'h00};
    end else begin
      pos_r    <= pos_nxt;
      prefix_r <= prefix_nxt;
      status_r <= status_nxt;
      number_r <= number_nxt;
    end
  end

endmodule

FILE: rtl/crp_queue.sv
`timescale 1ns / 1ps
// Short request queue between front and back end, QUEUE_DEPTH entries.
// Depends on crp_pkg.
module crp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  crp_pkg::crp_req_t    din,
  input  logic                 pop,
  output crp_pkg::crp_req_t    dout,
  output crp_pkg::crp_q_stat_t stat
);
  import crp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  crp_req_t         mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/crp_back.sv
`timescale 1ns / 1ps
// Back end: held card number and hex text, builds result beats into the output
// register. Depends on crp_pkg.
module crp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  crp_pkg::crp_req_t req,
  output logic              req_pop,
  output logic              out_valid,
  input  logic              out_pop,
  output crp_pkg::crp_out_t out_beat
);
  import crp_pkg::*;

  logic [31:0] held_num_r, held_num_nxt;
  logic [63:0] held_hex_r, held_hex_nxt;
  logic        out_valid_r, out_valid_nxt;
  crp_out_t    out_r, out_nxt;
  logic [63:0] hex_new;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hex_new[63 - 8*i -: 8] = hex_char(req.number[31 - 4*i -: 4]);
    end
  end

  assign req_pop = req_valid && (!out_valid_r || out_pop);

  always_comb begin
    held_num_nxt  = held_num_r;
    held_hex_nxt  = held_hex_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (req_pop) begin
      if (req.card_ok) begin
        held_num_nxt = req.number;
        held_hex_nxt = hex_new;
      end
      out_nxt.card_found    = req.card_ok;
      out_nxt.card_number   = held_num_nxt;
      out_nxt.hex_text_high = held_hex_nxt[63:32];
      out_nxt.hex_text_low  = held_hex_nxt[31:0];
      out_valid_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_num_r  <= '0;
      held_hex_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_num_r  <= held_num_nxt;
      held_hex_r  <= held_hex_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

FILE: rtl/card_reader_reply_parser_unit.sv
`timescale 1ns / 1ps
// Card reader reply parser, top level. Instantiates crp_front, crp_queue and
// crp_back; depends on crp_pkg.
//
// Input channel: push/full queue of beats {op, rx_byte}. Byte beats advance the
// reply position and capture prefix, status and card bytes; clear beats restart
// the reply; extract beats produce one result beat each. Unused op codes are
// dropped. One beat per cycle is accepted whenever full is low.
// Result channel: empty/pop queue of {card_found, card_number, hex_text_high,
// hex_text_low}. An extract beat passes through the request queue, then the output
// register, before it shows up on the result ports; results stream at one per cycle
// while pop stays high.
// When the receiver stalls, the output register holds its beat, the two-entry
// request queue fills, and full rises; byte and clear beats also wait then.
// Reset (synchronous, rst_n low) empties both queues and zeroes the position,
// captured bytes and the held card number and text.
module card_reader_reply_parser_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  crp_pkg::crp_in_t  in_beat,
  output logic              out_empty,
  input  logic              out_pop,
  output crp_pkg::crp_out_t out_beat
);
  import crp_pkg::*;

  logic        take;
  logic        q_push;
  crp_req_t    q_din;
  logic        q_pop;
  crp_req_t    q_dout;
  crp_q_stat_t q_stat;
  logic        out_valid;

  assign in_full   = q_stat.full;
  assign take      = in_push && !q_stat.full;
  assign out_empty = !out_valid;

  crp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_beat  (in_beat),
    .req_push (q_push),
    .req      (q_din)
  );

  crp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  crp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (!q_stat.empty),
    .req       (q_dout),
    .req_pop   (q_pop),
    .out_valid (out_valid),
    .out_pop   (out_pop),
    .out_beat  (out_beat)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("request pushed into full queue");

  a_pop_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_empty) else $error("popped request did not reach output");

  a_hex_matches_number: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_beat.card_found) |->
      (out_beat.hex_text_high[31:24] == hex_char(out_beat.card_number[31:28]) &&
       out_beat.hex_text_low[7:0] == hex_char(out_beat.card_number[3:0])))
    else $error("hex text does not match card number");
`endif

endmodule
